// ===== rtl/rgb_led_chain_transmitter_core_assert.svh =====
// assertion macros for the rgb led chain transmitter
`ifndef RGB_LED_CHAIN_TRANSMITTER_CORE_ASSERT_SVH
`define RGB_LED_CHAIN_TRANSMITTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RLCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlct assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RLCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlct assertion failed");

`endif

// ===== rtl/rlct_pkg.sv =====
// shared types, constants and functions of the rgb led chain transmitter
package rlct_pkg;

    localparam int NUM_PIXELS = 8;
    localparam int PIX_W      = $clog2(NUM_PIXELS);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [4:0]  LAST_BIT    = 5'd23;
    localparam logic [7:0]  START_LEVEL = 8'd64;
    localparam int          GREEN_END   = 3;
    localparam int          TEAL_END    = 6;

    localparam logic [7:0]  RST_ONE_HIGH   = 8'd6;
    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd3;
    localparam logic [7:0]  RST_BIT_PERIOD = 8'd10;
    localparam logic [15:0] RST_LATCH_LOW  = 16'd0;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_ROTATE,
        CMD_WRITE
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ONE_HIGH,
        REG_ZERO_HIGH,
        REG_BIT_PERIOD,
        REG_LATCH_LOW
    } reg_idx_t;

    typedef struct packed {
        cmd_t       command;
        logic [2:0] pixel_index;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic [7:0] blue_level;
    } in_word_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  one_high;
        logic [7:0]  zero_high;
        logic [7:0]  bit_period;
        logic [15:0] latch_low;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic rotate;
        logic write;
        logic send_tick;
        logic latch_tick;
        logic finish;
        logic idle_tick;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic level;
        logic bit_done;
        logic last_bit;
        logic latch_done;
        logic latch_zero;
        logic line_hold;
    } dp_status_t;

    // start pattern: green, then green plus blue, then red
    function automatic logic [23:0] start_pixel(input int idx);
        logic [23:0] px;
        if (idx < GREEN_END)
            px = {START_LEVEL, 8'd0, 8'd0};
        else if (idx < TEAL_END)
            px = {START_LEVEL, 8'd0, START_LEVEL};
        else
            px = {8'd0, START_LEVEL, 8'd0};
        return px;
    endfunction

endpackage

// ===== rtl/rlct_dp.sv =====
// datapath: pixel store, bit and tick counters, latch counter, held line level
module rlct_dp
    import rlct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  in_word_t   in_word,
    input  dp_cmd_t    cmd,
    output dp_status_t status
);

    logic [23:0]      store_reg  [NUM_PIXELS];
    logic [23:0]      store_next [NUM_PIXELS];
    logic [PIX_W-1:0] pixel_reg, pixel_next;
    logic [4:0]       bit_reg, bit_next;
    logic [7:0]       tick_reg, tick_next;
    logic [15:0]      latch_reg, latch_next;
    logic             hold_reg, hold_next;

    logic [23:0] cur_word;
    logic        bit_val;
    logic [7:0]  high_ticks;
    logic [15:0] latch_inc;
    logic        idx_ok;

    always_comb
    begin
        cur_word   = store_reg[pixel_reg];
        bit_val    = cur_word[LAST_BIT - bit_reg];
        high_ticks = bit_val ? cfg.one_high : cfg.zero_high;
        latch_inc  = latch_reg + 16'd1;

        status.level      = (tick_reg < high_ticks);
        status.bit_done   = (({1'b0, tick_reg} + 9'd1) >= {1'b0, cfg.bit_period});
        status.last_bit   = (bit_reg == LAST_BIT) &&
                            (pixel_reg == PIX_W'(NUM_PIXELS - 1));
        status.latch_done = (latch_inc >= cfg.latch_low);
        status.latch_zero = (cfg.latch_low == 16'd0);
        status.line_hold  = hold_reg;
    end

    // pixel store: rotate of all pixels at once, single-pixel write
    always_comb
    begin
        idx_ok = (int'(in_word.pixel_index) < NUM_PIXELS);
        for (int i = 0; i < NUM_PIXELS; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.rotate)
                store_next[i] = store_reg[(i + 1) % NUM_PIXELS];
            else if (cmd.write && idx_ok && (int'(in_word.pixel_index) == i))
                store_next[i] = {in_word.green_level, in_word.red_level,
                                 in_word.blue_level};
        end
    end

    // waveform counters
    always_comb
    begin
        pixel_next = pixel_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        latch_next = latch_reg;
        hold_next  = hold_reg;

        if (cmd.start)
        begin
            pixel_next = '0;
            bit_next   = '0;
            tick_next  = '0;
            latch_next = '0;
            hold_next  = 1'b0;
        end

        if (cmd.send_tick)
        begin
            hold_next = status.level;
            if (status.bit_done)
            begin
                tick_next = '0;
                if (bit_reg == LAST_BIT)
                begin
                    bit_next = '0;
                    if (pixel_reg == PIX_W'(NUM_PIXELS - 1))
                        pixel_next = '0;
                    else
                        pixel_next = pixel_reg + PIX_W'(1);
                end
                else
                begin
                    bit_next = bit_reg + 5'd1;
                end
            end
            else
            begin
                tick_next = tick_reg + 8'd1;
            end
        end

        if (cmd.latch_tick)
        begin
            latch_next = latch_inc;
            hold_next  = 1'b0;
        end

        if (cmd.idle_tick)
            hold_next = 1'b0;

        if (cmd.finish)
        begin
            latch_next = '0;
            hold_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PIXELS; i++)
                store_reg[i] <= start_pixel(i);
            pixel_reg <= '0;
            bit_reg   <= '0;
            tick_reg  <= '0;
            latch_reg <= '0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_PIXELS; i++)
                store_reg[i] <= store_next[i];
            pixel_reg <= pixel_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            latch_reg <= latch_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// ===== rtl/rlct_ctrl.sv =====
// controller: frame phase machine, command decode and output word register
module rlct_ctrl
    import rlct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_word,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_LATCH
    } phase_t;

    phase_t    phase_reg, phase_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    out_word_t res;
    logic      accept;
    logic      busy;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign busy      = (phase_reg != PH_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        cmd            = '0;
        res.line_level = 1'b0;
        res.busy_res   = busy;
        res.frame_done = 1'b0;

        if (accept)
        begin
            if (in_word.command != CMD_TICK)
            begin
                if (busy)
                begin
                    res.line_level = status.line_hold;
                end
                else
                begin
                    case (in_word.command)
                        CMD_START:
                        begin
                            cmd.start    = 1'b1;
                            phase_next   = PH_SEND;
                            res.busy_res = 1'b1;
                        end
                        CMD_ROTATE: cmd.rotate = 1'b1;
                        CMD_WRITE:  cmd.write  = 1'b1;
                        default:    ;
                    endcase
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SEND:
                    begin
                        cmd.send_tick  = 1'b1;
                        res.line_level = status.level;
                        res.busy_res   = 1'b1;
                        if (status.bit_done && status.last_bit)
                        begin
                            if (status.latch_zero)
                            begin
                                cmd.finish     = 1'b1;
                                phase_next     = PH_IDLE;
                                res.busy_res   = 1'b0;
                                res.frame_done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_LATCH;
                            end
                        end
                    end
                    PH_LATCH:
                    begin
                        cmd.latch_tick = 1'b1;
                        res.busy_res   = 1'b1;
                        if (status.latch_done)
                        begin
                            cmd.finish     = 1'b1;
                            phase_next     = PH_IDLE;
                            res.busy_res   = 1'b0;
                            res.frame_done = 1'b1;
                        end
                    end
                    default: cmd.idle_tick = 1'b1;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

`include "rgb_led_chain_transmitter_core_assert.svh"

    `RLCT_ASSERT_NXT(a_done_goes_idle, accept && res.frame_done, phase_reg == PH_IDLE)
    `RLCT_ASSERT_NXT(a_start_enters_send,
        accept && !busy && (in_word.command == CMD_START), phase_reg == PH_SEND)
    `RLCT_ASSERT_NXT(a_held_word_stays, out_valid_reg && out_stall && !accept,
        out_valid_reg && $stable(out_word_reg))
    `RLCT_ASSERT_IMP(a_busy_cmd_no_store, accept && busy && (in_word.command != CMD_TICK),
        !cmd.rotate && !cmd.write && !cmd.start)

endmodule

// ===== rtl/rgb_led_chain_transmitter_core.sv =====
// top level of the rgb led chain transmitter: config registers, controller, datapath
//
//  channel | dir | handshake                         | payload
//  --------+-----+-----------------------------------+--------------------------
//  in      | in  | in_valid / in_stall               | in_word  (in_word_t)
//  out     | out | out_valid / out_stall             | out_word (out_word_t)
//  config  | in  | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// rotate moves all pixels at once, so for every word (tick, start, rotate, write)
//   the rate is one per cycle while in_stall is low
// the result word lands in the output register in the cycle after acceptance
// a single output register parts the sides: in_stall is high only while that
//   register is full and the receiver stalls
// reset loads the start pattern into the pixel store, idles the frame and
//   sets the config registers to their default timing
// no clearing pass after reset; the block takes words from the first cycle
module rgb_led_chain_transmitter_core
    import rlct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input word channel
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_word,
    // result word channel
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_word,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg, cfg_next;
    reg_idx_t   reg_sel;
    logic       cfg_wr;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // register i sits at byte address 4*i
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write, taken in the access cycle
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_ONE_HIGH:   cfg_next.one_high   = pwdata[7:0];
                REG_ZERO_HIGH:  cfg_next.zero_high  = pwdata[7:0];
                REG_BIT_PERIOD: cfg_next.bit_period = pwdata[7:0];
                REG_LATCH_LOW:  cfg_next.latch_low  = pwdata[15:0];
                default:        ;
            endcase
        end
    end

    // register read-back, zero-padded to the bus width
    always_comb
    begin
        case (reg_sel)
            REG_ONE_HIGH:   prdata = {24'd0, cfg_reg.one_high};
            REG_ZERO_HIGH:  prdata = {24'd0, cfg_reg.zero_high};
            REG_BIT_PERIOD: prdata = {24'd0, cfg_reg.bit_period};
            REG_LATCH_LOW:  prdata = {16'd0, cfg_reg.latch_low};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high   <= RST_ONE_HIGH;
            cfg_reg.zero_high  <= RST_ZERO_HIGH;
            cfg_reg.bit_period <= RST_BIT_PERIOD;
            cfg_reg.latch_low  <= RST_LATCH_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // phase machine, command decode and the output register
    rlct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    // pixel store and waveform counters
    rlct_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_word (in_word),
        .cmd     (dp_cmd),
        .status  (dp_status)
    );

endmodule

// ===== sim/tb_rgb_led_chain_transmitter_core.sv =====
// testbench for the rgb led chain transmitter: directed and random words against a predictor
module tb_rgb_led_chain_transmitter_core
    import rlct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // no word moved in either direction for this many cycles means the block hung
    localparam int QUIET_LIMIT = 2000;
    // length of the long receiver hold-off in the backpressure test
    localparam int HOLD_CYCLES = 80;
    // brightness used by the power-up pattern of the pixel store
    localparam logic [7:0] BOOT_LEVEL = 8'd64;
    localparam int BITS_PER_PIXEL = 24;

    typedef enum logic [1:0] {
        FRAME_IDLE,
        FRAME_SEND,
        FRAME_LATCH
    } frame_phase_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_word_t          in_word;
    logic              out_valid;
    logic              out_stall;
    out_word_t         out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rgb_led_chain_transmitter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: its own copy of the pixel store, frame position
    // and timing registers
    // ------------------------------------------------------------------
    logic [23:0]  chain_colors [NUM_PIXELS];
    logic [7:0]   one_high_len;
    logic [7:0]   zero_high_len;
    logic [7:0]   bit_len;
    logic [15:0]  latch_len;
    int           px_pos;
    int           bit_pos;
    int           tick_pos;
    logic [15:0]  latch_pos;
    frame_phase_t frame_phase;
    logic         held_line;

    // expected result words, oldest first
    out_word_t line_expect_q [$];

    // idling knobs, percent of cycles
    int send_gap_pct;
    int stall_pct;
    bit hold_request;

    // bookkeeping for the verdict and summary
    int words_sent;
    int results_seen;
    int frames_seen;
    int stall_seen;
    int mismatch_count;
    int stray_count;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // power-up pattern: green pixels, then green plus blue, then red
    task automatic reset_chain_model();
        int i;
        for (i = 0; i < NUM_PIXELS; i++) begin
            if (i < 3)
                chain_colors[i] = {BOOT_LEVEL, 8'd0, 8'd0};
            else if (i < 6)
                chain_colors[i] = {BOOT_LEVEL, 8'd0, BOOT_LEVEL};
            else
                chain_colors[i] = {8'd0, BOOT_LEVEL, 8'd0};
        end
        one_high_len  = 8'd6;
        zero_high_len = 8'd3;
        bit_len       = 8'd10;
        latch_len     = 16'd0;
        px_pos        = 0;
        bit_pos       = 0;
        tick_pos      = 0;
        latch_pos     = '0;
        frame_phase   = FRAME_IDLE;
        held_line     = 1'b0;
    endtask

    // last tick of a frame (or of its latch): drop busy, flag done
    function automatic void close_frame(inout out_word_t res);
        frame_phase    = FRAME_IDLE;
        latch_pos      = '0;
        held_line      = 1'b0;
        res.busy_res   = 1'b0;
        res.frame_done = 1'b1;
    endfunction

    // apply one accepted word to the predictor and return the result it causes
    function automatic out_word_t advance_chain(input in_word_t w);
        out_word_t   res;
        logic [23:0] first_px;
        logic [7:0]  high_len;
        logic        level;
        int          i;
        res = '0;
        res.busy_res = (frame_phase != FRAME_IDLE);

        if (w.command != CMD_TICK) begin
            // start, rotate and write are dropped during a frame; the line holds
            if (frame_phase != FRAME_IDLE) begin
                res.line_level = held_line;
                return res;
            end
            case (w.command)
                CMD_START: begin
                    frame_phase  = FRAME_SEND;
                    px_pos       = 0;
                    bit_pos      = 0;
                    tick_pos     = 0;
                    latch_pos    = '0;
                    held_line    = 1'b0;
                    res.busy_res = 1'b1;
                end
                CMD_ROTATE: begin
                    first_px = chain_colors[0];
                    for (i = 0; i < NUM_PIXELS - 1; i++)
                        chain_colors[i] = chain_colors[i + 1];
                    chain_colors[NUM_PIXELS - 1] = first_px;
                end
                default: begin
                    if (int'(w.pixel_index) < NUM_PIXELS)
                        chain_colors[w.pixel_index] =
                            {w.green_level, w.red_level, w.blue_level};
                end
            endcase
            return res;
        end

        case (frame_phase)
            FRAME_SEND: begin
                high_len = chain_colors[px_pos][BITS_PER_PIXEL - 1 - bit_pos] ?
                           one_high_len : zero_high_len;
                level = (tick_pos < int'(high_len));
                held_line      = level;
                res.line_level = level;
                res.busy_res   = 1'b1;
                // periods below two still give one tick per bit
                if (tick_pos + 1 >= int'(bit_len)) begin
                    tick_pos = 0;
                    bit_pos++;
                    if (bit_pos >= BITS_PER_PIXEL) begin
                        bit_pos = 0;
                        px_pos++;
                        if (px_pos >= NUM_PIXELS) begin
                            px_pos = 0;
                            if (latch_len == 16'd0) begin
                                close_frame(res);
                            end else begin
                                frame_phase = FRAME_LATCH;
                                latch_pos   = '0;
                            end
                        end
                    end
                end else begin
                    tick_pos++;
                end
            end
            FRAME_LATCH: begin
                latch_pos      = latch_pos + 16'd1;
                held_line      = 1'b0;
                res.busy_res   = 1'b1;
                if (latch_pos >= latch_len)
                    close_frame(res);
            end
            default: held_line = 1'b0;
        endcase
        return res;
    endfunction

    // random payload with the given command; every payload bit gets exercised
    function automatic in_word_t random_word(input cmd_t c);
        in_word_t    w;
        logic [31:0] raw;
        raw = $urandom();
        w = in_word_t'(raw[$bits(in_word_t)-1:0]);
        w.command = c;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // input side: offer one word, wait for it to be taken, predict
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        line_expect_q.push_back(advance_chain(w));
        words_sent++;
    endtask

    // stop offering, then wait until every result is back plus the pipe latency
    task automatic settle_block();
        in_valid <= 1'b0;
        while (line_expect_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // apb write, then read the register back and compare
    task automatic program_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (idx == REG_LATCH_LOW) ? 32'h0000_ffff : 32'h0000_00ff;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_ONE_HIGH:   one_high_len  = value[7:0];
            REG_ZERO_HIGH:  zero_high_len = value[7:0];
            REG_BIT_PERIOD: bit_len       = value[7:0];
            default:        latch_len     = value[15:0];
        endcase
        // read back: new setup cycle with psel still high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (value & mask)) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= 10)
                $display("register %s read back %h, wrote %h", idx.name(), got & mask,
                         value & mask);
        end
    endtask

    task automatic set_timing(input logic [7:0] one_hi, input logic [7:0] zero_hi,
                              input logic [7:0] period, input logic [15:0] latch);
        settle_block();
        program_reg(REG_ONE_HIGH, {24'd0, one_hi});
        program_reg(REG_ZERO_HIGH, {24'd0, zero_hi});
        program_reg(REG_BIT_PERIOD, {24'd0, period});
        program_reg(REG_LATCH_LOW, {16'd0, latch});
    endtask

    // drive ticks until the predicted frame is over, sprinkling in commands
    // that a busy block must drop
    task automatic tick_until_idle(input int noise_pct, output int ticks);
        ticks = 0;
        while (frame_phase != FRAME_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                send_word(random_word(cmd_t'($urandom_range(1, 3))));
            end else begin
                send_word(random_word(CMD_TICK));
                ticks++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timing and power-up pattern, every command, writes at the index
    // and color extremes, and commands dropped while a frame runs
    task automatic test_directed_commands();
        in_word_t w;
        send_gap_pct = 0;
        stall_pct    = 0;
        // idle tick with every payload bit set
        w = '1;
        w.command = CMD_TICK;
        send_word(w);
        // writes: last pixel all ones, first pixel all zeros, mixed bits
        w = '1;
        w.command = CMD_WRITE;
        send_word(w);
        w = '0;
        w.command = CMD_WRITE;
        send_word(w);
        w.pixel_index = 3'd3;
        w.green_level = 8'h80;
        w.red_level   = 8'h01;
        w.blue_level  = 8'h7f;
        send_word(w);
        // rotate twice: first pixel wraps to the end each time
        send_word(random_word(CMD_ROTATE));
        send_word(random_word(CMD_ROTATE));
        send_word(random_word(CMD_TICK));
        // frame start, then commands that must be dropped while busy
        send_word(random_word(CMD_START));
        send_word(random_word(CMD_START));
        send_word(random_word(CMD_ROTATE));
        send_word(random_word(CMD_WRITE));
        repeat (8) send_word(random_word(CMD_TICK));
        // start and rotate repeat the held line level; the tick goes on sending
        send_word(random_word(CMD_START));
        send_word(random_word(CMD_ROTATE));
        send_word(random_word(CMD_TICK));
    endtask

    // register extremes, timing changed in the middle of a frame, pulses
    // as long as the bit or longer, and bits of one tick
    task automatic test_frame_timing();
        int ticks;
        // extremes are only read back: no tick runs under them
        set_timing(8'd255, 8'd255, 8'd255, 16'hffff);
        // the directed frame is still running: both pulses outlast the bit
        set_timing(8'd255, 8'd9, 8'd4, 16'd0);
        repeat (16) send_word(random_word(CMD_TICK));
        // one pulse minimal, zero pulse exactly one bit long
        set_timing(8'd1, 8'd4, 8'd4, 16'd0);
        repeat (8) send_word(random_word(CMD_TICK));
        // periods below two give one tick per bit; no latch, so the last
        // bit tick ends the frame
        set_timing(8'd1, 8'd1, 8'd1, 16'd0);
        tick_until_idle(0, ticks);
    endtask

    // random words under each idling mix: setup commands and a start, then
    // mostly ticks with commands mixed in; one frame spans the phases
    task automatic test_random_traffic();
        int gap_pcts [4];
        int stall_pcts [4];
        int ph;
        int period;
        gap_pcts   = '{0, 71, 0, 15};
        stall_pcts = '{0, 0, 71, 15};
        for (ph = 0; ph < 4; ph++) begin
            period = $urandom_range(1, 2);
            set_timing(8'($urandom_range(1, period + 1)),
                       8'($urandom_range(1, period + 1)),
                       8'(period), 16'($urandom_range(0, 6)));
            send_gap_pct = gap_pcts[ph];
            stall_pct    = stall_pcts[ph];
            // applied while idle, dropped once the frame runs
            repeat (3) begin
                case ($urandom_range(0, 3))
                    0:       send_word(random_word(CMD_TICK));
                    1:       send_word(random_word(CMD_ROTATE));
                    default: send_word(random_word(CMD_WRITE));
                endcase
            end
            send_word(random_word(CMD_START));
            repeat (16) begin
                if ($urandom_range(99) < 15)
                    send_word(random_word(cmd_t'($urandom_range(1, 3))));
                else
                    send_word(random_word(CMD_TICK));
            end
        end
        send_gap_pct = 0;
        stall_pct    = 0;
    endtask

    // receiver holds off for a long stretch while words keep coming, so the
    // output register fills and the input stalls
    task automatic test_backpressure();
        settle_block();
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        repeat (30) send_word(random_word(cmd_t'($urandom_range(0, 3))));
    endtask

    // the running frame ends on its latch: one-tick bits, then a short low
    // stretch before done
    task automatic test_latch_end();
        int ticks;
        set_timing(8'd1, 8'd2, 8'd1, 16'd3);
        tick_until_idle(4, ticks);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, or a counted hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: each taken word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (out_word.frame_done === 1'b1)
                frames_seen++;
            if (line_expect_q.size() == 0) begin
                stray_count++;
                if (mismatch_count + stray_count <= 10)
                    $display("%0t: result with nothing expected: %b %b %b", $time,
                             out_word.line_level, out_word.busy_res, out_word.frame_done);
            end else begin
                want = line_expect_q.pop_front();
                if (out_word.line_level !== want.line_level ||
                    out_word.busy_res !== want.busy_res ||
                    out_word.frame_done !== want.frame_done) begin
                    mismatch_count++;
                    if (mismatch_count + stray_count <= 10)
                        $display("%0t: expected line/busy/done %b%b%b, got %b%b%b", $time,
                                 want.line_level, want.busy_res, want.frame_done,
                                 out_word.line_level, out_word.busy_res,
                                 out_word.frame_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no word moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (in_valid && in_stall)
                stall_seen++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word moved for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        send_gap_pct   = 0;
        stall_pct      = 0;
        hold_request   = 1'b0;
        words_sent     = 0;
        results_seen   = 0;
        frames_seen    = 0;
        stall_seen     = 0;
        mismatch_count = 0;
        stray_count    = 0;
        in_valid <= 1'b0;
        in_word  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        reset_chain_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_frame_timing();
        test_random_traffic();
        test_backpressure();
        test_latch_end();

        // drain, then let the registered result words reach the checker
        settle_block();
        repeat (4) @(posedge clk);

        $display("sent %0d words, checked %0d results, %0d frames finished",
                 words_sent, results_seen, frames_seen);
        $display("input stalled %0d cycles; %0d mismatches, %0d stray, %0d missing",
                 stall_seen, mismatch_count, stray_count, line_expect_q.size());
        if (mismatch_count == 0 && stray_count == 0 && line_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
